/* rtl/psar_pkg.sv */
// Package for the picture-processor scroll and address register unit.
// Holds the access codes, raster timing constants, address masks and the result record.
// No dependencies.
package psar_pkg;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_CTRL   = 3'd1,
    MODE_SCROLL = 3'd2,
    MODE_ADDR   = 3'd3,
    MODE_DATA   = 3'd4,
    MODE_STATUS = 3'd5
  } mode_t;

  localparam logic [9:0] DOTS_PER_LINE     = 10'd341;
  localparam logic [9:0] LINES_PER_FRAME   = 10'd262;
  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
  localparam logic [8:0] VBLANK_LINE       = 9'd241;
  localparam logic [8:0] PRERENDER_LINE    = 9'd261;

  localparam logic [14:0] HORIZ_BITS = 15'h041F;
  localparam logic [14:0] VERT_BITS  = 15'h7BE0;

  typedef struct packed {
    logic [14:0] addr_v;
    logic [14:0] temp_t;
    logic [2:0]  fine_x;
    logic        toggle;
    logic        vblank;
    logic        nmi;
    logic [8:0]  line;
    logic [8:0]  dot;
  } res_t;

endpackage

/* rtl/ppu_scroll_address_registers.sv */
// Top level of the picture-processor scroll and address register unit (v, t, fine X, toggle)
// with its own scanline and dot counters. Depends on psar_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one transaction per dot tick or per
//   register access, selected by in_mode; in_data_byte is the byte written for control,
//   scroll and address writes. The result channel (out_valid/out_ready) returns one
//   transaction per input with the register and counter values after that input, plus
//   the derived tile and attribute fetch addresses.
//   A result is registered: it enters the result register, or the skid register while the
//   result register stays occupied. Throughput is one item per cycle while in_ready is high;
//   the combinational path is the update logic of v (coarse X step, Y step and copies from t).
//   When the receiver stalls, the result register holds and a one-entry skid register
//   takes one more result; in_ready drops only while the skid entry is occupied.
//   Reset (rst_n low, synchronous) clears all state registers and counters to zero and
//   empties both result stages.
//   Mode codes 6 and 7 leave the state untouched and report it unchanged.
module ppu_scroll_address_registers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [14:0] out_addr_v,
  output logic [14:0] out_temp_t,
  output logic [2:0]  out_fine_scroll_x,
  output logic        out_write_toggle,
  output logic [13:0] out_tile_fetch_addr,
  output logic [13:0] out_attr_fetch_addr,
  output logic        out_vblank_flag,
  output logic        out_nmi_pulse,
  output logic [8:0]  out_line_now,
  output logic [8:0]  out_dot_now
);
  import psar_pkg::*;

  logic [14:0] v_r, v_nxt;
  logic [14:0] t_r, t_nxt;
  logic [2:0]  fx_r, fx_nxt;
  logic        w_r, w_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic        vbl_r, vbl_nxt;
  logic [8:0]  line_r, line_nxt;
  logic [8:0]  dot_r, dot_nxt;
  logic        pulse;

  res_t res_r, res_nxt;
  res_t skid_r, skid_nxt;
  logic out_vld_r, out_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  logic in_acc;

  function automatic logic [14:0] coarse_x_step(input logic [14:0] v);
    logic [14:0] r;
    if (v[4:0] == 5'd31) begin
      r = {v[14:11], ~v[10], v[9:5], 5'd0};
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] y_step(input logic [14:0] v);
    logic [14:0] r;
    logic [4:0]  cy;
    logic        nt;
    if (v[14:12] != 3'd7) begin
      r = v + 15'h1000;
    end else begin
      cy = v[9:5];
      nt = v[11];
      if (cy == 5'd29) begin
        cy = 5'd0;
        nt = ~nt;
      end else if (cy == 5'd31) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r = {3'd0, nt, v[10], cy, v[4:0]};
    end
    return r;
  endfunction

  assign in_ready = !skid_vld_r;
  assign in_acc   = in_valid && in_ready;

  // Next-state logic for one item.
  always_comb begin
    logic        render_line;
    logic        cx_en;
    logic [14:0] vt;
    logic [9:0]  dot_inc;
    logic [9:0]  line_inc;

    v_nxt    = v_r;
    t_nxt    = t_r;
    fx_nxt   = fx_r;
    w_nxt    = w_r;
    ctrl_nxt = ctrl_r;
    vbl_nxt  = vbl_r;
    line_nxt = line_r;
    dot_nxt  = dot_r;
    pulse    = 1'b0;

    render_line = (line_r <= LAST_VISIBLE_LINE) || (line_r == PRERENDER_LINE);
    cx_en = ((dot_r >= 9'd8) && (dot_r <= 9'd256) && (dot_r[2:0] == 3'd0)) ||
            (dot_r == 9'd328) || (dot_r == 9'd336);
    dot_inc  = {1'b0, dot_r} + 10'd1;
    line_inc = {1'b0, line_r} + 10'd1;
    vt = v_r;

    case (in_mode)
      MODE_TICK: begin
        if (dot_r == 9'd1) begin
          if (line_r == VBLANK_LINE) begin
            vbl_nxt = 1'b1;
            pulse   = ctrl_r[7];
          end else if (line_r == PRERENDER_LINE) begin
            vbl_nxt = 1'b0;
          end
        end
        if (render_line) begin
          // At dot 256 the coarse X step comes first and the Y step follows it.
          if (cx_en) begin
            vt = coarse_x_step(vt);
          end
          if (dot_r == 9'd256) begin
            vt = y_step(vt);
          end
          if (dot_r == 9'd257) begin
            vt = (vt & ~HORIZ_BITS) | (t_r & HORIZ_BITS);
          end
          if ((line_r == PRERENDER_LINE) && (dot_r >= 9'd280) && (dot_r <= 9'd304)) begin
            vt = (vt & ~VERT_BITS) | (t_r & VERT_BITS);
          end
        end
        v_nxt = vt;
        if (dot_inc >= DOTS_PER_LINE) begin
          dot_nxt = 9'd0;
          if (line_inc >= LINES_PER_FRAME) begin
            line_nxt = 9'd0;
          end else begin
            line_nxt = line_inc[8:0];
          end
        end else begin
          dot_nxt = dot_inc[8:0];
        end
      end
      MODE_CTRL: begin
        ctrl_nxt = in_data_byte;
        t_nxt    = {t_r[14:12], in_data_byte[1:0], t_r[9:0]};
      end
      MODE_SCROLL: begin
        if (!w_r) begin
          t_nxt  = {t_r[14:5], in_data_byte[7:3]};
          fx_nxt = in_data_byte[2:0];
        end else begin
          t_nxt = {in_data_byte[2:0], t_r[11:10], in_data_byte[7:3], t_r[4:0]};
        end
        w_nxt = ~w_r;
      end
      MODE_ADDR: begin
        if (!w_r) begin
          t_nxt = {1'b0, in_data_byte[5:0], t_r[7:0]};
        end else begin
          t_nxt = {t_r[14:8], in_data_byte};
          v_nxt = {t_r[14:8], in_data_byte};
        end
        w_nxt = ~w_r;
      end
      MODE_DATA: begin
        v_nxt = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);
      end
      MODE_STATUS: begin
        w_nxt   = 1'b0;
        vbl_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result record and the two-entry output stage.
  always_comb begin
    res_t fresh;
    fresh.addr_v = v_nxt;
    fresh.temp_t = t_nxt;
    fresh.fine_x = fx_nxt;
    fresh.toggle = w_nxt;
    fresh.vblank = vbl_nxt;
    fresh.nmi    = pulse;
    fresh.line   = line_nxt;
    fresh.dot    = dot_nxt;

    res_nxt      = res_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;

    if (out_vld_r && out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (skid_vld_r && (!out_vld_r || out_ready)) begin
      res_nxt      = skid_r;
      out_vld_nxt  = 1'b1;
      skid_vld_nxt = 1'b0;
    end
    if (in_acc) begin
      if (!out_vld_nxt) begin
        res_nxt     = fresh;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = fresh;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= '0;
      t_r        <= '0;
      fx_r       <= '0;
      w_r        <= 1'b0;
      ctrl_r     <= '0;
      vbl_r      <= 1'b0;
      line_r     <= '0;
      dot_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v_r    <= v_nxt;
        t_r    <= t_nxt;
        fx_r   <= fx_nxt;
        w_r    <= w_nxt;
        ctrl_r <= ctrl_nxt;
        vbl_r  <= vbl_nxt;
        line_r <= line_nxt;
        dot_r  <= dot_nxt;
      end
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid           = out_vld_r;
  assign out_addr_v          = res_r.addr_v;
  assign out_temp_t          = res_r.temp_t;
  assign out_fine_scroll_x   = res_r.fine_x;
  assign out_write_toggle    = res_r.toggle;
  assign out_tile_fetch_addr = {2'b10, res_r.addr_v[11:0]};
  assign out_attr_fetch_addr = {2'b10, res_r.addr_v[11:10], 4'b1111,
                                res_r.addr_v[9:7], res_r.addr_v[4:2]};
  assign out_vblank_flag     = res_r.vblank;
  assign out_nmi_pulse       = res_r.nmi;
  assign out_line_now        = res_r.line;
  assign out_dot_now         = res_r.dot;

endmodule

/* rtl/psar_checker.sv */
// Port-level checker for the scroll and address register unit, bound to its top level.
// Depends on psar_pkg and ppu_scroll_address_registers.
module psar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] out_addr_v,
  input logic [13:0] out_tile_fetch_addr,
  input logic        out_vblank_flag,
  input logic        out_nmi_pulse,
  input logic [8:0]  out_line_now,
  input logic [8:0]  out_dot_now
);
  import psar_pkg::*;

  // An NMI pulse is only reported for the tick at dot 1 of the vblank line.
  a_nmi_timing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nmi_pulse |->
      out_vblank_flag && (out_dot_now == 9'd2) && (out_line_now == VBLANK_LINE))
    else $error("nmi pulse outside vblank start");

  a_counters_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_dot_now} < DOTS_PER_LINE) &&
                  ({1'b0, out_line_now} < LINES_PER_FRAME))
    else $error("raster counter out of range");

  a_tile_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tile_fetch_addr[13:12] == 2'b10) &&
                  (out_tile_fetch_addr[11:0] == out_addr_v[11:0]))
    else $error("tile fetch address does not follow v");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_addr_v) && $stable(out_dot_now))
    else $error("result changed while stalled");

endmodule

bind ppu_scroll_address_registers psar_checker u_psar_checker (.*);
